// ===== src/hrma_pkg.sv =====
// Shared types and constants for the heart rate moving average block.
package hrma_pkg;

    // Field widths
    localparam int IR_W     = 18;
    localparam int TIME_W   = 32;
    localparam int RATE_W   = 8;

    // Ring of accepted rates
    localparam int RING_DEPTH = 4;
    localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W      = RATE_W + POS_W;

    // Serial interval subtractor: DIGIT_W bits per cycle
    localparam int DIGIT_W   = 2;
    localparam int SUB_STEPS = TIME_W / DIGIT_W;
    localparam int STEP_W    = 5;

    // Shared restoring divider
    localparam int DIV_W     = 16;
    localparam int DIVISOR_W = 12;

    // Rate arithmetic
    localparam int unsigned MS_PER_MINUTE   = 60000;
    localparam int unsigned MIN_INTERVAL    = 236;
    localparam int unsigned MAX_INTERVAL    = 2999;
    localparam int unsigned THRESHOLD_RESET = 7000;
    localparam int unsigned MAX_SUM         = RING_DEPTH * 254;

    // Rate quotient is below 256 for every accepted interval, so the divider
    // starts with the top dividend bits already folded into the remainder.
    localparam int RATE_STEPS = RATE_W;
    localparam logic [DIVISOR_W-1:0] RATE_REM_INIT =
        DIVISOR_W'(MS_PER_MINUTE >> RATE_STEPS);
    localparam logic [DIV_W-1:0] RATE_DIVIDEND =
        DIV_W'((MS_PER_MINUTE % (1 << RATE_STEPS)) << (DIV_W - RATE_STEPS));

    // Input word
    typedef struct packed {
        logic [IR_W-1:0]   ir_level;
        logic              beat_seen;
        logic [TIME_W-1:0] time_ms;
    } hrma_in_t;

    // Result word
    typedef struct packed {
        logic [RATE_W-1:0] average_rate;
        logic              finger_present;
        logic              rate_accepted;
    } hrma_out_t;

    // Interval unit status
    typedef struct packed {
        logic                 done;
        logic                 in_range;
        logic [DIVISOR_W-1:0] interval;
    } ivl_res_t;

    // Divider request
    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] rem_init;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
        logic [STEP_W-1:0]    steps;
    } div_req_t;

    // Ring write request
    typedef struct packed {
        logic              wr;
        logic [RATE_W-1:0] rate;
    } ring_wr_t;

endpackage

// ===== src/hrma_interval.sv =====
// Digit-serial beat interval subtractor holding the last beat time.
module hrma_interval (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [hrma_pkg::TIME_W-1:0]  now,
    output hrma_pkg::ivl_res_t           res
);
    import hrma_pkg::*;

    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic [TIME_W-1:0]  diff_reg, diff_next;
    logic               borrow_reg, borrow_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DIGIT_W:0]   digit;

    // One digit of now - last, LSB first
    assign digit = {1'b0, now_reg[DIGIT_W-1:0]} - {1'b0, last_reg[DIGIT_W-1:0]}
                   - {{DIGIT_W{1'b0}}, borrow_reg};

    always_comb begin
        now_next    = now_reg;
        last_next   = last_reg;
        diff_next   = diff_reg;
        borrow_next = borrow_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start) begin
            now_next    = now;
            borrow_next = 1'b0;
            cnt_next    = STEP_W'(SUB_STEPS);
        end else if (cnt_reg != '0) begin
            // last beat time rotates in the new timestamp as it shifts out
            now_next    = now_reg >> DIGIT_W;
            last_next   = {now_reg[DIGIT_W-1:0], last_reg[TIME_W-1:DIGIT_W]};
            diff_next   = {digit[DIGIT_W-1:0], diff_reg[TIME_W-1:DIGIT_W]};
            borrow_next = digit[DIGIT_W];
            cnt_next    = cnt_reg - 1'b1;
            done_next   = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        now_reg  <= now_next;
        diff_reg <= diff_next;
        if (!aresetn) begin
            last_reg   <= '0;
            borrow_reg <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end else begin
            last_reg   <= last_next;
            borrow_reg <= borrow_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    // Accepted intervals fit the divisor width
    assign res.done     = done_reg;
    assign res.in_range = (diff_reg[TIME_W-1:DIVISOR_W] == '0)
                          && (diff_reg[DIVISOR_W-1:0] >= DIVISOR_W'(MIN_INTERVAL))
                          && (diff_reg[DIVISOR_W-1:0] <= DIVISOR_W'(MAX_INTERVAL));
    assign res.interval = diff_reg[DIVISOR_W-1:0];

endmodule

// ===== src/hrma_divider.sv =====
// Shared bit-serial restoring divider, one quotient bit per cycle.
module hrma_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hrma_pkg::div_req_t           req,
    output logic                         done,
    output logic [hrma_pkg::RATE_W-1:0]  quotient
);
    import hrma_pkg::*;

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [RATE_W-1:0]    q_reg, q_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 fits;

    // Trial subtract of the shifted remainder
    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = req.rem_init;
            dvd_next = req.dividend;
            dsr_next = req.divisor;
            q_next   = '0;
            cnt_next = req.steps;
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            dvd_next  = dvd_reg << 1;
            q_next    = {q_reg[RATE_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/hrma_ring.sv =====
// Ring of accepted rates with a running sum.
module hrma_ring (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hrma_pkg::ring_wr_t          wr_req,
    output logic [hrma_pkg::SUM_W-1:0]  sum
);
    import hrma_pkg::*;

    logic [RATE_W-1:0] ring_reg [RING_DEPTH];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [RATE_W-1:0] old_rate;

    assign old_rate = ring_reg[pos_reg];

    // Replace the oldest entry and adjust the sum
    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (wr_req.wr) begin
            sum_next = sum_reg - SUM_W'(old_rate) + SUM_W'(wr_req.rate);
            pos_next = (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end else begin
            if (wr_req.wr) begin
                ring_reg[pos_reg] <= wr_req.rate;
            end
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== src/heart_rate_moving_average.sv =====
// Heart rate moving average: top level with control sequencer and output register.
//
// Input channel s_valid / s_ready / s_data carries one sensor word: IR level,
// beat flag and millisecond timestamp. Result channel m_valid / m_ready /
// m_data returns exactly one word per input word, in order.
// cfg_wr_en / cfg_wr_data write the presence threshold.
// One word is worked at a time. A word with no finger or no beat goes
// straight to the done state, a beat with an out-of-range interval after
// the interval subtractor. A present beat with an accepted interval passes
// the 2-bit-per-cycle interval subtractor, 8 quotient bits of 60000/interval and
// SUM_W (10) quotient bits of sum/RING_DEPTH through the shared bit-serial
// divider, and the control states. The next word is taken only once the
// result of the last one has been loaded into the output register.
// s_ready is high whenever the sequencer is idle, so a new word is taken
// while the previous result still sits in the output register. If the
// receiver stalls, the next result waits in the sequencer until the output
// register frees, and no further word is taken meanwhile.
// Synchronous active-low reset clears the ring, last beat time, average
// and handshakes, and sets the threshold to 7000; no clearing pass is needed.
module heart_rate_moving_average (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [hrma_pkg::IR_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  hrma_pkg::hrma_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output hrma_pkg::hrma_out_t        m_data
);
    import hrma_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUB  = 6'b000010,
        ST_RATE = 6'b000100,
        ST_RING = 6'b001000,
        ST_AVG  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [IR_W-1:0]   thr_reg, thr_next;
    logic [RATE_W-1:0] shown_reg, shown_next;
    logic              present_reg, present_next;
    logic              accepted_reg, accepted_next;
    logic              m_valid_reg, m_valid_next;
    hrma_out_t         m_data_reg, m_data_next;

    logic              s_fire;
    logic              present_in;
    logic              out_free;
    logic              ivl_start;
    ivl_res_t          ivl_res;
    div_req_t          div_req;
    logic              div_done;
    logic [RATE_W-1:0] div_q;
    ring_wr_t          ring_wr;
    logic [SUM_W-1:0]  ring_sum;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign present_in = (s_data.ir_level > thr_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign ivl_start  = s_fire && present_in && s_data.beat_seen;

    hrma_interval u_interval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ivl_start),
        .now     (s_data.time_ms),
        .res     (ivl_res)
    );

    // Divider requests: rate after the interval, average after the ring write
    always_comb begin
        div_req = '0;
        if ((state_reg == ST_SUB) && ivl_res.done && ivl_res.in_range) begin
            div_req.start    = 1'b1;
            div_req.rem_init = RATE_REM_INIT;
            div_req.dividend = RATE_DIVIDEND;
            div_req.divisor  = ivl_res.interval;
            div_req.steps    = STEP_W'(RATE_STEPS);
        end else if (state_reg == ST_RING) begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.dividend = {ring_sum, {(DIV_W - SUM_W){1'b0}}};
            div_req.divisor  = DIVISOR_W'(RING_DEPTH);
            div_req.steps    = STEP_W'(SUM_W);
        end
    end

    hrma_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ring_wr.wr   = (state_reg == ST_RATE) && div_done;
    assign ring_wr.rate = div_q;

    hrma_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (ring_wr),
        .sum     (ring_sum)
    );

    // Threshold register
    assign thr_next = cfg_wr_en ? cfg_wr_data : thr_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        shown_next    = shown_reg;
        present_next  = present_reg;
        accepted_next = accepted_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    present_next  = present_in;
                    accepted_next = 1'b0;
                    if (!present_in) begin
                        shown_next = '0;
                        state_next = ST_DONE;
                    end else if (s_data.beat_seen) begin
                        state_next = ST_SUB;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SUB: begin
                if (ivl_res.done) begin
                    state_next = ivl_res.in_range ? ST_RATE : ST_DONE;
                end
            end
            ST_RATE: begin
                if (div_done) begin
                    state_next = ST_RING;
                end
            end
            ST_RING: begin
                state_next = ST_AVG;
            end
            ST_AVG: begin
                if (div_done) begin
                    shown_next    = div_q;
                    accepted_next = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next               = 1'b1;
            m_data_next.average_rate   = shown_reg;
            m_data_next.finger_present = present_reg;
            m_data_next.rate_accepted  = accepted_reg;
        end
    end

    always_ff @(posedge aclk) begin
        present_reg  <= present_next;
        accepted_reg <= accepted_next;
        m_data_reg   <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= IR_W'(THRESHOLD_RESET);
            shown_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            shown_reg   <= shown_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // One word in flight: nothing is taken right after a word is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("word accepted while previous word in flight");

    // No finger means a zero average and no stored rate
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.finger_present) |->
            (m_data.average_rate == '0) && !m_data.rate_accepted)
        else $error("absent finger with nonzero average or stored rate");

    // Running sum never exceeds a full ring of the largest rate
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_sum <= SUM_W'(MAX_SUM))
        else $error("ring sum out of range");

    // A divider start never reports done on the following cycle
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> !div_done)
        else $error("divider done right after start");
`endif

endmodule
